FILE: hw/rtl/ssca_pkg.sv
package ssca_pkg;

  typedef enum logic [2:0] {
    REQ_CLEAR     = 3'd0,
    REQ_INS_PERM  = 3'd1,
    REQ_INS_PLAN  = 3'd2,
    REQ_NEAREST   = 3'd3,
    REQ_NEXT_PERM = 3'd4,
    REQ_DRAIN     = 3'd5,
    REQ_RST_PLAN  = 3'd6,
    REQ_RST_PERM  = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_NQ_RD,
    S_NQ_CHK,
    S_DUP_RD,
    S_DUP_CHK,
    S_NX_RD,
    S_DR_RD,
    S_DR_OUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0] slot_value;
    logic        found;
    logic        last;
    status_t     status;
  } result_t;

  localparam logic [7:0] ADDR_GUARD = 8'h00;

endpackage

FILE: hw/rtl/ssca_table.sv
module ssca_table #(
  parameter int DEPTH = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sorted_slot_cursor_allocator.sv
// Sorted slot cursor allocator.
// Requests enter on the s_axis channel: tdata[2:0] is the request type and
// tdata[34:3] the signed moment. Results leave on m_axis: tdata[31:0] is the
// slot value, tdata[32] found, tdata[34:33] status, and tlast marks the final
// result of a request. Every request gives one result, except a drain, which
// gives one result per unused planned slot (up to the table depth), or one
// result with status none when none is left. One request is handled at a
// time. Both tables live in single-port-read synchronous memories; an insert
// walks from the tail down, shifting each larger entry up by one. A nearest
// query scans from the cursor, then rescans from the start for the first
// duplicate of the hit. Drain emits the unused planned slots in order.
// A result waits in the output register while the receiver stalls; the
// block holds its walk until that register is free.
// Reset empties both tables and rewinds both cursors; the guard margin
// register, written over the APB port, resets to zero.
module sorted_slot_cursor_allocator #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // req_type[2:0], moment[34:3], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // slot_value[31:0], found[32], status[34:33]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [15:0] guard;
  ssca_pkg::state_t state, state_next;
  logic        sel_plan;      // walk is on the planned table
  logic signed [31:0] mom;
  logic [CW-1:0] perm_cnt, perm_used, plan_cnt, plan_used;
  logic [CW-1:0] idx;
  logic [31:0]   hit_val;
  ssca_pkg::result_t res;
  logic          res_valid;
  logic          res_load;
  ssca_pkg::status_t acc_status;

  // memories
  logic          pm_we, pl_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, pm_rd, pl_rd, rd;

  ssca_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_perm (
    .clk(clk), .we(pm_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(pm_rd)
  );
  ssca_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_plan (
    .clk(clk), .we(pl_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(pl_rd)
  );

  assign rd = sel_plan ? pl_rd : pm_rd;
  assign pready = 1'b1;
  assign prdata = {16'd0, guard};
  assign s_axis_tready = (state == ssca_pkg::S_IDLE) && !res_valid;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = {5'd0, res.status, res.found, res.slot_value};
  assign m_axis_tlast = res.last;

  logic signed [33:0] lhs;
  assign lhs = 34'(signed'(rd)) - 34'(signed'({1'b0, guard}));
  logic out_free;
  assign out_free = !res_valid || m_axis_tready;

  // Starting status of the first result, set when the request is taken.
  // A full insert answers full; a drain with nothing left answers none without a walk.
  always_comb begin
    acc_status = ssca_pkg::ST_OK;
    case (ssca_pkg::req_t'(s_axis_tdata[2:0]))
      ssca_pkg::REQ_INS_PERM: if (perm_cnt >= DEPTH_C) acc_status = ssca_pkg::ST_FULL;
      ssca_pkg::REQ_INS_PLAN: if (plan_cnt >= DEPTH_C) acc_status = ssca_pkg::ST_FULL;
      ssca_pkg::REQ_DRAIN:    if (plan_used >= plan_cnt) acc_status = ssca_pkg::ST_NONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      guard <= '0;
    end else if (psel && penable && pwrite && paddr == ssca_pkg::ADDR_GUARD[1:0]) begin
      guard <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssca_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Memory access decode is combinational on the current state.
  always_comb begin
    pm_we = 1'b0;
    pl_we = 1'b0;
    waddr = idx[AW-1:0];
    wdata = mom;
    raddr = idx[AW-1:0];
    res_load = 1'b0;
    state_next = state;
    unique case (state)
      ssca_pkg::S_IDLE: begin
        // Keep the permitted cursor entry on the read port for next-permitted.
        raddr = perm_used[AW-1:0];
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (ssca_pkg::req_t'(s_axis_tdata[2:0]))
            ssca_pkg::REQ_INS_PERM: state_next = (perm_cnt >= DEPTH_C) ?
                                      ssca_pkg::S_RESP : ssca_pkg::S_INS_RD;
            ssca_pkg::REQ_INS_PLAN: state_next = (plan_cnt >= DEPTH_C) ?
                                      ssca_pkg::S_RESP : ssca_pkg::S_INS_RD;
            ssca_pkg::REQ_NEAREST:   state_next = ssca_pkg::S_NQ_RD;
            ssca_pkg::REQ_NEXT_PERM: state_next = ssca_pkg::S_NX_RD;
            ssca_pkg::REQ_DRAIN:     state_next = ssca_pkg::S_DR_RD;
            default:                 state_next = ssca_pkg::S_RESP;
          endcase
        end
      end
      ssca_pkg::S_INS_RD: begin
        raddr = AW'(idx - CW'(1));
        if (idx == '0) begin
          pm_we = !sel_plan;
          pl_we = sel_plan;
          state_next = ssca_pkg::S_RESP;
        end else begin
          state_next = ssca_pkg::S_INS_CHK;
        end
      end
      ssca_pkg::S_INS_CHK: begin
        pm_we = !sel_plan;
        pl_we = sel_plan;
        if ($signed(rd) > mom) begin
          wdata = rd;
          state_next = ssca_pkg::S_INS_RD;
        end else begin
          state_next = ssca_pkg::S_RESP;
        end
      end
      ssca_pkg::S_NQ_RD: begin
        state_next = (idx < perm_cnt) ? ssca_pkg::S_NQ_CHK : ssca_pkg::S_RESP;
      end
      ssca_pkg::S_NQ_CHK: begin
        state_next = (lhs >= 34'(mom)) ? ssca_pkg::S_DUP_RD : ssca_pkg::S_NQ_RD;
      end
      ssca_pkg::S_DUP_RD:  state_next = ssca_pkg::S_DUP_CHK;
      ssca_pkg::S_DUP_CHK: begin
        state_next = (rd == hit_val) ? ssca_pkg::S_RESP : ssca_pkg::S_DUP_RD;
      end
      ssca_pkg::S_NX_RD:   state_next = ssca_pkg::S_RESP;
      ssca_pkg::S_DR_RD: begin
        // An empty drain skips the walk.
        if (idx >= plan_cnt) begin
          res_load = 1'b1;
          state_next = ssca_pkg::S_IDLE;
        end else begin
          state_next = ssca_pkg::S_DR_OUT;
        end
      end
      ssca_pkg::S_DR_OUT: begin
        if (out_free) begin
          res_load = 1'b1;
          state_next = (idx + CW'(1) < plan_cnt) ? ssca_pkg::S_DR_RD : ssca_pkg::S_IDLE;
        end
      end
      ssca_pkg::S_RESP: begin
        if (out_free) begin
          res_load = 1'b1;
          state_next = ssca_pkg::S_IDLE;
        end
      end
      default: state_next = ssca_pkg::S_IDLE;
    endcase
  end

  // Datapath and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_cnt  <= '0;
      perm_used <= '0;
      plan_cnt  <= '0;
      plan_used <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (m_axis_tready) res_valid <= 1'b0;
      unique case (state)
        ssca_pkg::S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mom <= s_axis_tdata[34:3];
            res <= '{slot_value: '0, found: 1'b0, last: 1'b1, status: acc_status};
            sel_plan <= 1'b0;
            unique case (ssca_pkg::req_t'(s_axis_tdata[2:0]))
              ssca_pkg::REQ_CLEAR: begin
                perm_cnt <= '0; perm_used <= '0; plan_cnt <= '0; plan_used <= '0;
              end
              ssca_pkg::REQ_INS_PERM: idx <= perm_cnt;
              ssca_pkg::REQ_INS_PLAN: begin
                idx <= plan_cnt;
                sel_plan <= 1'b1;
              end
              ssca_pkg::REQ_NEAREST, ssca_pkg::REQ_NEXT_PERM: idx <= perm_used;
              ssca_pkg::REQ_DRAIN: begin
                idx <= plan_used;
                sel_plan <= 1'b1;
              end
              ssca_pkg::REQ_RST_PLAN: plan_used <= '0;
              default: perm_used <= '0;
            endcase
          end
        end
        ssca_pkg::S_INS_RD: begin
          if (idx == '0) begin
            if (sel_plan) plan_cnt <= plan_cnt + CW'(1);
            else perm_cnt <= perm_cnt + CW'(1);
          end
        end
        ssca_pkg::S_INS_CHK: begin
          if ($signed(rd) > mom) begin
            idx <= idx - CW'(1);
          end else if (sel_plan) begin
            plan_cnt <= plan_cnt + CW'(1);
          end else begin
            perm_cnt <= perm_cnt + CW'(1);
          end
        end
        ssca_pkg::S_NQ_RD: begin
          if (idx >= perm_cnt) res.status <= ssca_pkg::ST_NONE;
        end
        ssca_pkg::S_NQ_CHK: begin
          if (lhs >= 34'(mom)) begin
            hit_val <= rd;
            idx <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ssca_pkg::S_DUP_CHK: begin
          if (rd == hit_val) begin
            perm_used <= idx + CW'(1);
            res.slot_value <= hit_val;
            res.found <= 1'b1;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ssca_pkg::S_NX_RD: begin
          if (idx < perm_cnt) begin
            perm_used <= idx + CW'(1);
            res.slot_value <= pm_rd;
            res.found <= 1'b1;
          end else begin
            res.status <= ssca_pkg::ST_NONE;
          end
        end
        ssca_pkg::S_DR_OUT: begin
          if (out_free) begin
            res <= '{slot_value: rd, found: 1'b1,
                     last: !(idx + CW'(1) < plan_cnt), status: ssca_pkg::ST_OK};
            plan_used <= idx + CW'(1);
            idx <= idx + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ssca_checker.sv
module ssca_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[34:33] == 2'd0)
    else $error("found result with bad status");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0 && m_axis_tlast)
    else $error("empty result carries data");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind sorted_slot_cursor_allocator ssca_checker u_ssca_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

FILE: dv/sorted_slot_cursor_allocator_tb.sv
`timescale 1ns / 1ps

module sorted_slot_cursor_allocator_tb;
  import ssca_pkg::*;

  localparam int DEPTH = 32;
  localparam int MAX_DRAIN = 32;
  localparam int HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] GUARD_ADDR = ADDR_GUARD[1:0];

  typedef struct {
    req_t        kind;
    logic [31:0] moment;
  } slot_req_t;

  typedef struct {
    logic [31:0] slot_value;
    logic        found;
    logic        last;
    status_t     status;
  } slot_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sorted_slot_cursor_allocator u_top (.*);

  always #2 clk = ~clk;

  // Model of the block's tables, cursors and guard register.
  logic signed [31:0] perm_tab [DEPTH];
  logic signed [31:0] plan_tab [DEPTH];
  int perm_cnt, perm_used, plan_cnt, plan_used;
  logic [15:0] guard;

  slot_req_t  pending_reqs[$];
  slot_resp_t expected_resps[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  in_fire = 1'b0;
  bit  quiet_input = 1'b0;
  bit  quiet_output = 1'b0;
  bit  hold_wanted = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  function automatic slot_resp_t ack(status_t st);
    slot_resp_t r;
    r.slot_value = '0;
    r.found = 1'b0;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

  task automatic sorted_add(ref logic signed [31:0] tab [DEPTH], ref int cnt,
                            input logic signed [31:0] v);
    int pos;
    if (cnt >= DEPTH) begin
      expected_resps.push_back(ack(ST_FULL));
      return;
    end
    pos = cnt;
    // Equal slots stay ahead of the new one.
    while (pos > 0 && tab[pos-1] > v) begin
      tab[pos] = tab[pos-1];
      pos--;
    end
    tab[pos] = v;
    cnt++;
    expected_resps.push_back(ack(ST_OK));
  endtask

  task automatic predict_slots(input req_t kind, input logic signed [31:0] mom);
    slot_resp_t r;
    longint lhs;
    int j, k;
    bit hit;
    case (kind)
      REQ_CLEAR: begin
        perm_cnt = 0; perm_used = 0; plan_cnt = 0; plan_used = 0;
        expected_resps.push_back(ack(ST_OK));
      end
      REQ_INS_PERM: sorted_add(perm_tab, perm_cnt, mom);
      REQ_INS_PLAN: sorted_add(plan_tab, plan_cnt, mom);
      REQ_NEAREST: begin
        hit = 1'b0;
        for (int i = perm_used; i < perm_cnt && !hit; i++) begin
          lhs = longint'(perm_tab[i]) - longint'(guard);
          if (lhs >= longint'(mom)) begin
            hit = 1'b1;
            j = 0;
            while (j < i && perm_tab[j] != perm_tab[i]) j++;
            perm_used = j + 1;
            r = ack(ST_OK);
            r.slot_value = perm_tab[i];
            r.found = 1'b1;
            expected_resps.push_back(r);
          end
        end
        if (!hit) expected_resps.push_back(ack(ST_NONE));
      end
      REQ_NEXT_PERM: begin
        if (perm_used < perm_cnt) begin
          r = ack(ST_OK);
          r.slot_value = perm_tab[perm_used];
          r.found = 1'b1;
          perm_used++;
          expected_resps.push_back(r);
        end else begin
          expected_resps.push_back(ack(ST_NONE));
        end
      end
      REQ_DRAIN: begin
        k = 0;
        while (plan_used < plan_cnt && k < MAX_DRAIN) begin
          r = ack(ST_OK);
          r.slot_value = plan_tab[plan_used];
          r.found = 1'b1;
          plan_used++;
          k++;
          r.last = !(plan_used < plan_cnt && k < MAX_DRAIN);
          expected_resps.push_back(r);
        end
        if (k == 0) expected_resps.push_back(ack(ST_NONE));
      end
      REQ_RST_PLAN: begin
        plan_used = 0;
        expected_resps.push_back(ack(ST_OK));
      end
      default: begin
        perm_used = 0;
        expected_resps.push_back(ack(ST_OK));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Request side: the model advances on every accepted request and guard register write.
  always @(posedge clk) begin
    in_fire = s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (in_fire) predict_slots(req_t'(s_axis_tdata[2:0]), s_axis_tdata[34:3]);
      if (psel && penable && pwrite && pready && paddr == GUARD_ADDR)
        guard = pwdata[15:0];
    end
  end

  // Result side.
  always @(posedge clk) begin
    slot_resp_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sorted_slot_cursor_allocator: FAILED **");
      $finish;
    end else if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_resps.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_resps.pop_front();
        if (m_axis_tdata[31:0] !== want.slot_value)
          report_mismatch("slot_value", m_axis_tdata[31:0], want.slot_value);
        if (m_axis_tdata[32] !== want.found)
          report_mismatch("found", 32'(m_axis_tdata[32]), 32'(want.found));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tdata[34:33] !== want.status)
          report_mismatch("status", 32'(m_axis_tdata[34:33]), 32'(want.status));
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    slot_req_t nxt;
    if (!rst && (in_fire || !s_axis_tvalid)) begin
      if (pending_reqs.size() > 0 && (quiet_input || $urandom_range(99) >= 33)) begin
        nxt = pending_reqs.pop_front();
        s_axis_tdata <= {5'b0, nxt.moment, nxt.kind};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (hold_wanted && !hold_done && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && (quiet_output || $urandom_range(99) >= 33);
    end
  end

  task automatic add_req(input req_t kind, input logic [31:0] mom);
    slot_req_t r;
    r.kind = kind;
    r.moment = mom;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] pick_moment();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 32'h7fff_fff0 + $urandom_range(15)
                                  : 32'h8000_0000 + $urandom_range(15);
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic add_random(input int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 2) begin
        // Insert a burst of 34 slots, each into a table picked at random.
        for (int f = 0; f < 34; f++)
          add_req($urandom_range(1) ? REQ_INS_PERM : REQ_INS_PLAN, pick_moment());
      end else if (p < 6) add_req(REQ_CLEAR, pick_moment());
      else if (p < 32) add_req(REQ_INS_PERM, pick_moment());
      else if (p < 52) add_req(REQ_INS_PLAN, pick_moment());
      else if (p < 70) add_req(REQ_NEAREST, pick_moment());
      else if (p < 82) add_req(REQ_NEXT_PERM, pick_moment());
      else if (p < 90) add_req(REQ_DRAIN, pick_moment());
      else if (p < 95) add_req(REQ_RST_PLAN, pick_moment());
      else add_req(REQ_RST_PERM, pick_moment());
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_guard(input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= GUARD_ADDR; pwdata <= {16'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  initial begin
    perm_cnt = 0; perm_used = 0; plan_cnt = 0; plan_used = 0; guard = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_req(REQ_CLEAR, 32'h0);
    add_req(REQ_INS_PERM, 32'h8000_0000);
    add_req(REQ_INS_PERM, 32'h7fff_ffff);
    add_req(REQ_INS_PERM, 32'h0);
    add_req(REQ_INS_PERM, 32'h0);
    add_req(REQ_INS_PLAN, 32'h7fff_ffff);
    add_req(REQ_INS_PLAN, 32'h8000_0000);
    add_req(REQ_NEAREST, 32'h7fff_ffff);
    add_req(REQ_NEAREST, 32'h0);
    add_req(REQ_NEXT_PERM, 32'hffff_ffff);
    add_req(REQ_NEXT_PERM, 32'h0);
    add_req(REQ_NEXT_PERM, 32'h0);
    add_req(REQ_NEAREST, 32'h1);
    add_req(REQ_DRAIN, 32'h0);
    add_req(REQ_DRAIN, 32'h0);
    add_req(REQ_RST_PLAN, 32'h0);
    add_req(REQ_DRAIN, 32'h0);
    add_req(REQ_RST_PERM, 32'h0);
    add_req(REQ_NEAREST, 32'h8000_0000);
    add_req(REQ_NEAREST, 32'hffff_ffff);
    add_req(REQ_CLEAR, 32'h0);
    wait_idle();

    // The largest margin pushes slots near the bottom below any moment.
    write_guard(16'hffff);
    add_random(65);
    wait_idle();

    write_guard(16'($urandom_range(200)));
    quiet_input = 1'b1;
    quiet_output = 1'b1;
    add_random(60);
    wait_idle();
    quiet_input = 1'b0;
    quiet_output = 1'b0;

    write_guard(16'($urandom()));
    hold_wanted = 1'b1;
    add_random(80);
    wait_idle();

    write_guard(16'h0);
    add_random(65);
    wait_idle();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("** sorted_slot_cursor_allocator: PASSED **");
    end else begin
      $display("** sorted_slot_cursor_allocator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ssca_pkg.sv
hw/rtl/ssca_table.sv
hw/rtl/sorted_slot_cursor_allocator.sv
hw/rtl/ssca_checker.sv
dv/sorted_slot_cursor_allocator_tb.sv
